FILE: design/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types and constants of the mesh center-of-mass core.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int SUM_BITS       = 64;
    localparam int QDEPTH         = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VOL = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TERM,
        BK_WGT,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } back_state_t;

    // beat handed from front to back
    typedef struct packed {
        logic signed [19:0] ax, ay, az;
        logic signed [19:0] bx, by, bz;
        logic signed [19:0] cx, cy, cz;
        logic               last;
    } face_t;

endpackage

FILE: design/mcm_front.sv
// ----------------------------------------------------------------------------
// mcm_front
// Accept triangle beats and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module mcm_front #(
    parameter int COORD_BITS = mcm_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COORD_BITS-1:0] coord [9],
    input  logic                 last,
    output logic                 q_valid,
    input  logic                 q_pop,
    output mcm_pkg::face_t       q_data
);
    import mcm_pkg::*;

    face_t       mem_reg [QDEPTH];
    logic [0:0]  wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    face_t       f;
    logic        push;

    always_comb
    begin
        f      = '0;
        f.ax   = 20'(signed'(coord[0]));
        f.ay   = 20'(signed'(coord[1]));
        f.az   = 20'(signed'(coord[2]));
        f.bx   = 20'(signed'(coord[3]));
        f.by   = 20'(signed'(coord[4]));
        f.bz   = 20'(signed'(coord[5]));
        f.cx   = 20'(signed'(coord[6]));
        f.cy   = 20'(signed'(coord[7]));
        f.cz   = 20'(signed'(coord[8]));
        f.last = last;
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count overrun");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");

endmodule

FILE: design/mcm_back.sv
// ----------------------------------------------------------------------------
// mcm_back
// Compute the tetrahedron terms, accumulate sums, divide on the last face.
// ----------------------------------------------------------------------------
module mcm_back #(
    parameter int COORD_BITS = mcm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  mcm_pkg::face_t        q_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] cx,
    output logic [COORD_BITS-1:0] cy,
    output logic [COORD_BITS-1:0] cz,
    output logic [1:0]            status
);
    import mcm_pkg::*;

    localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SMIN = {1'b1, 63'd0};
    // cross product and term magnitude widths, sized from the coordinates
    localparam int KW = 2*COORD_BITS + 1;
    localparam int MW = 3*COORD_BITS;

    back_state_t st_reg, st_next;
    face_t       f_reg;
    logic signed [KW-1:0] k_reg [3];
    logic signed [63:0] t_reg;
    logic [MW-1:0]  tm_reg;
    logic [COORD_BITS:0] sm_reg [3];
    logic         neg_reg [3];
    logic [127:0] p_reg [3];
    logic signed [63:0] vol_reg, ws_reg [3];
    logic         ovf_reg;
    logic         last_reg;
    // divider
    logic [1:0]   ax_reg;
    logic [6:0]   it_reg;
    logic [127:0] num_reg;
    logic [65:0]  den_reg;
    logic [66:0]  rem_reg;
    logic [32:0]  q_reg;
    logic [COORD_BITS-1:0] res_reg [3];
    logic [1:0]   status_reg;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                output logic o);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        o = 1'b0;
        if (s > 65'(SMAX)) begin o = 1'b1; return SMAX; end
        if (s < 65'(SMIN)) begin o = 1'b1; return SMIN; end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_q(input logic [32:0] q, input logic n);
        logic signed [34:0] v;
        v = n ? -35'(q) : 35'(q);
        if (v > 35'((1 << (COORD_BITS - 1)) - 1))
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        if (v < -35'(1 << (COORD_BITS - 1)))
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        return v[COORD_BITS-1:0];
    endfunction

    logic signed [63:0] wt [3];
    logic               wo [3];
    logic [127:0]       sh [3];
    logic signed [63:0] ws_n [3];
    logic               ao [4];
    logic signed [63:0] vol_n;
    logic [66:0]        rem_sh;
    logic               ge;
    logic [33:0]        q_w;
    logic [32:0]        q_sh;
    logic [1:0]         ax_nx;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = p_reg[i] >> FRAC_BITS;
            wo[i] = (sh[i][127:64] != 0) ||
                    (sh[i][63:0] > (neg_reg[i] ? 64'(SMIN) : 64'(SMAX)));
            if (wo[i])
            begin
                wt[i] = neg_reg[i] ? SMIN : SMAX;
            end
            else
            begin
                wt[i] = neg_reg[i] ? -signed'(sh[i][63:0]) : signed'(sh[i][63:0]);
            end
        end
        vol_n = sadd(vol_reg, t_reg, ao[3]);
        for (int i = 0; i < 3; i++)
        begin
            ws_n[i] = sadd(ws_reg[i], wt[i], ao[i]);
        end
        rem_sh = {rem_reg[65:0], num_reg[127]};
        ge     = rem_sh >= 67'(den_reg);
        // hold the quotient at 2^32 once it gets there
        q_w    = {q_reg, ge};
        if (q_w > 34'h1_0000_0000)
        begin
            q_sh = 33'h1_0000_0000;
        end
        else
        begin
            q_sh = q_w[32:0];
        end
        ax_nx = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
    end

    always_comb
    begin
        st_next = st_reg;
        q_pop   = 1'b0;
        unique case (st_reg)
            BK_IDLE: if (q_valid) begin q_pop = 1'b1; st_next = BK_TERM; end
            BK_TERM: st_next = BK_WGT;
            BK_WGT:  st_next = BK_ACC;
            BK_ACC:  st_next = last_reg ? BK_DIV : BK_IDLE;
            BK_DIV:  if (it_reg == 7'd0 && ax_reg == 2'd2) st_next = BK_OUT;
            BK_OUT:  if (out_ready) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    // term stage: cross product then dot, sums of coordinates
    logic signed [63:0] dot;
    assign dot = -(64'(f_reg.ax) * 64'(k_reg[0]) + 64'(f_reg.ay) * 64'(k_reg[1])
                 + 64'(f_reg.az) * 64'(k_reg[2]));

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            BK_IDLE:
            begin
                f_reg    <= q_data;
                last_reg <= q_data.last;
                k_reg[0] <= KW'(64'(q_data.by) * 64'(q_data.cz)
                              - 64'(q_data.bz) * 64'(q_data.cy));
                k_reg[1] <= KW'(64'(q_data.bz) * 64'(q_data.cx)
                              - 64'(q_data.bx) * 64'(q_data.cz));
                k_reg[2] <= KW'(64'(q_data.bx) * 64'(q_data.cy)
                              - 64'(q_data.by) * 64'(q_data.cx));
            end
            BK_TERM:
            begin
                logic signed [21:0] s [3];
                s[0] = 22'(f_reg.ax) + 22'(f_reg.bx) + 22'(f_reg.cx);
                s[1] = 22'(f_reg.ay) + 22'(f_reg.by) + 22'(f_reg.cy);
                s[2] = 22'(f_reg.az) + 22'(f_reg.bz) + 22'(f_reg.cz);
                t_reg  <= dot;
                tm_reg <= MW'(mag(dot));
                for (int i = 0; i < 3; i++)
                begin
                    sm_reg[i]  <= (COORD_BITS+1)'(s[i][21] ? -s[i] : s[i]);
                    neg_reg[i] <= dot[63] != s[i][21];
                end
            end
            BK_WGT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= 128'(tm_reg) * 128'(sm_reg[i]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            vol_reg    <= '0;
            ws_reg     <= '{default: '0};
            ovf_reg    <= 1'b0;
            ax_reg     <= '0;
            it_reg     <= '0;
            num_reg    <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            res_reg    <= '{default: '0};
            status_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            unique case (st_reg)
                BK_ACC:
                begin
                    vol_reg <= vol_n;
                    for (int i = 0; i < 3; i++)
                    begin
                        ws_reg[i] <= ws_n[i];
                    end
                    ovf_reg <= ovf_reg | ao[0] | ao[1] | ao[2] | ao[3] | wo[0] | wo[1] | wo[2];
                    ax_reg  <= 2'd0;
                    it_reg  <= 7'd127;
                    rem_reg <= '0;
                    q_reg   <= '0;
                    num_reg <= 128'(mag(ws_n[0])) << FRAC_BITS;
                    den_reg <= {mag(vol_n), 2'b00};
                end
                BK_DIV:
                begin
                    if (it_reg == 7'd0)
                    begin
                        // last bit of this axis: store it and load the next axis
                        res_reg[ax_reg] <= sat_q(q_sh, ws_reg[ax_reg][63] != vol_reg[63]);
                        rem_reg <= '0;
                        q_reg   <= '0;
                        it_reg  <= 7'd127;
                        ax_reg  <= ax_reg + 2'd1;
                        num_reg <= 128'(mag(ws_reg[ax_nx])) << FRAC_BITS;
                        if (ax_reg == 2'd2)
                        begin
                            if (ovf_reg)
                            begin
                                status_reg <= ST_OVERFLOW;
                            end
                            else if (vol_reg == 0)
                            begin
                                status_reg <= ST_ZERO_VOL;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                            end
                        end
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        rem_reg <= ge ? rem_sh - 67'(den_reg) : rem_sh;
                        q_reg   <= q_sh;
                        it_reg  <= it_reg - 7'd1;
                    end
                end
                BK_OUT:
                begin
                    if (out_ready)
                    begin
                        vol_reg <= '0;
                        ws_reg  <= '{default: '0};
                        ovf_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    logic bad;
    assign bad       = (status_reg != ST_OK);
    assign out_valid = (st_reg == BK_OUT);
    assign cx        = bad ? '0 : res_reg[0];
    assign cy        = bad ? '0 : res_reg[1];
    assign cz        = bad ? '0 : res_reg[2];
    assign status    = status_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == BK_IDLE) else $error("pop outside idle");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (vol_reg == 0 && !ovf_reg))
        else $error("sums not cleared");
    a_ax: assert property (@(posedge clk) disable iff (!rst_n)
        ax_reg != 2'd3 || st_reg != BK_DIV) else $error("axis index overrun");

endmodule

FILE: design/mesh_center_of_mass_core.sv
// ----------------------------------------------------------------------------
// mesh_center_of_mass_core
// Centroid of a closed triangle mesh by signed tetrahedra.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one triangle per beat; tlast marks the final face of the mesh.
//  - m_axis: one centroid beat per mesh, after the last face.
//  - A two-entry queue sits between the accept side and the arithmetic, so
//    the feeder can push while the back end works.
//  - Per face the back-end sequencer steps through pop with cross products,
//    dot product, weight multiply and accumulate before it pops the next face.
//  - Last face: a restoring divider works through the three axes in turn;
//    the centroid beat is offered once all three axes are done.
//  - Overflow in any sum gives status 2 and zero coordinates; zero volume
//    gives status 1.
//  - Reset clears all sums and the queue; no clearing pass.
//  - A stalled receiver holds the result; the queue then fills and tready
//    drops.
// ----------------------------------------------------------------------------
module mesh_center_of_mass_core #(
    parameter int COORD_BITS = mcm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = mcm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // center_x, center_y, center_z, status from bit 0 up
    output logic [((3*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import mcm_pkg::*;

    localparam int OW = ((3*COORD_BITS+2+7)/8)*8;

    logic [COORD_BITS-1:0] coord [9];
    logic                  q_valid, q_pop;
    face_t                 q_data;
    logic [COORD_BITS-1:0] cx, cy, cz;
    logic [1:0]            status;

    // Split the packed triangle into its coordinates.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            coord[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    mcm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .coord    (coord),
        .last     (s_axis_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    mcm_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cx        (cx),
        .cy        (cy),
        .cz        (cz),
        .status    (status)
    );

    // Pack the result beat, zero fill above status.
    assign m_axis_tdata = OW'({status, cz, cy, cx});

endmodule

FILE: tb/tb_mesh_center_of_mass_core.sv
// ----------------------------------------------------------------------------
// tb_mesh_center_of_mass_core
// Self-checking bench for the mesh center-of-mass core: drives triangle beats,
// predicts each centroid beat in place, and compares every output field.
// ----------------------------------------------------------------------------
module tb_mesh_center_of_mass_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mcm_pkg::*;

    localparam int CB = 16;
    localparam int FB = 12;
    localparam int S_W = ((9*CB+7)/8)*8;
    localparam int M_W = ((3*CB+2+7)/8)*8;

    typedef struct packed {
        logic signed [CB-1:0] x, y, z;
    } vec_t;

    typedef struct {
        logic signed [CB-1:0] cx, cy, cz;
        status_t              st;
    } centroid_t;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic           s_axis_tlast;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [M_W-1:0] m_axis_tdata;   // center_x, center_y, center_z, status

    mesh_center_of_mass_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Running sums of the predictor, mirroring the block's accumulators.
    logic signed [63:0] vol_acc;
    logic signed [63:0] wsum_x, wsum_y, wsum_z;
    logic               sum_ovf;

    centroid_t centroid_q[$];
    int        err_count;
    bit        send_busy_free;   // 1: sender inserts no gaps
    bit        recv_busy_free;   // 1: receiver never stalls
    int        hold_cycles;      // long receiver hold-off request

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("[mesh_center_of_mass_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            sum_ovf = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (s < -65'sh0_8000_0000_0000_0000)
        begin
            sum_ovf = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return s[63:0];
    endfunction

    // (t * s) >> FB with the magnitude truncated, saturated to 64 signed bits
    function automatic logic signed [63:0] weight_term(input logic signed [63:0] t,
                                                       input logic signed [63:0] s);
        logic [127:0] mag;
        logic [127:0] lim;
        bit           neg;
        neg = (t < 0) != (s < 0);
        mag = 128'($unsigned(t < 0 ? -t : t)) * 128'($unsigned(s < 0 ? -s : s));
        mag = mag >> FB;
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (mag > lim)
        begin
            sum_ovf = 1'b1;
            return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    // w * 2^FB / (4 v), truncated toward zero, clamped to the coordinate range
    function automatic logic signed [CB-1:0] center_axis(input logic signed [63:0] w,
                                                          input logic signed [63:0] v);
        logic [127:0]       num;
        logic [127:0]       den;
        logic [127:0]       q;
        logic signed [63:0] val;
        num = 128'($unsigned(w < 0 ? -w : w)) << FB;
        den = 128'($unsigned(v < 0 ? -v : v)) << 2;
        q = num / den;
        if (q > (128'd1 << 32))
            q = 128'd1 << 32;
        val = ((w < 0) != (v < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
        if (val > 64'sd32767)
            val = 64'sd32767;
        if (val < -64'sd32768)
            val = -64'sd32768;
        return val[CB-1:0];
    endfunction

    task automatic predict_face(input vec_t a, input vec_t b, input vec_t c,
                                input bit last);
        logic signed [63:0] kx, ky, kz, t;
        centroid_t          res;
        kx = 64'(b.y) * 64'(c.z) - 64'(b.z) * 64'(c.y);
        ky = 64'(b.z) * 64'(c.x) - 64'(b.x) * 64'(c.z);
        kz = 64'(b.x) * 64'(c.y) - 64'(b.y) * 64'(c.x);
        t  = -(64'(a.x) * kx + 64'(a.y) * ky + 64'(a.z) * kz);
        vol_acc = add_sat(vol_acc, t);
        wsum_x = add_sat(wsum_x, weight_term(t, 64'(a.x) + 64'(b.x) + 64'(c.x)));
        wsum_y = add_sat(wsum_y, weight_term(t, 64'(a.y) + 64'(b.y) + 64'(c.y)));
        wsum_z = add_sat(wsum_z, weight_term(t, 64'(a.z) + 64'(b.z) + 64'(c.z)));
        if (last)
        begin
            res.cx = '0;
            res.cy = '0;
            res.cz = '0;
            if (sum_ovf)
                res.st = ST_OVERFLOW;
            else if (vol_acc == 0)
                res.st = ST_ZERO_VOL;
            else
            begin
                res.st = ST_OK;
                res.cx = center_axis(wsum_x, vol_acc);
                res.cy = center_axis(wsum_y, vol_acc);
                res.cz = center_axis(wsum_z, vol_acc);
            end
            centroid_q.insert(centroid_q.size(), res);
            vol_acc = '0;
            wsum_x  = '0;
            wsum_y  = '0;
            wsum_z  = '0;
            sum_ovf = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one triangle beat, gap drawn per beat, predict on accept
    // ------------------------------------------------------------------
    task automatic send_face(input vec_t a, input vec_t b, input vec_t c, input bit last);
        int gap;
        gap = send_busy_free ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.z, c.y, c.x, b.z, b.y, b.x, a.z, a.y, a.x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_face(a, b, c, last);
    endtask

    function automatic vec_t rand_vec(input int span);
        vec_t v;
        if (span >= 32768)
        begin
            v.x = CB'($urandom);
            v.y = CB'($urandom);
            v.z = CB'($urandom);
        end
        else
        begin
            v.x = CB'($urandom_range(0, 2*span) - span);
            v.y = CB'($urandom_range(0, 2*span) - span);
            v.z = CB'($urandom_range(0, 2*span) - span);
        end
        return v;
    endfunction

    // Send a mesh of random faces; span picks small or full-range coordinates.
    task automatic send_rand_mesh(input int faces, input int span);
        for (int i = 0; i < faces; i++)
            send_face(rand_vec(span), rand_vec(span), rand_vec(span), i == faces - 1);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            wait_n = recv_busy_free ? 0 : $urandom_range(0, 6);
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        centroid_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (centroid_q.size() == 0)
            begin
                report_mismatch("unexpected centroid beats", 1, 0);
            end
            else
            begin
                want = centroid_q.pop_front();
                if (m_axis_tdata[15:0] !== want.cx)
                    report_mismatch("center_x", $signed(m_axis_tdata[15:0]), want.cx);
                if (m_axis_tdata[31:16] !== want.cy)
                    report_mismatch("center_y", $signed(m_axis_tdata[31:16]), want.cy);
                if (m_axis_tdata[47:32] !== want.cz)
                    report_mismatch("center_z", $signed(m_axis_tdata[47:32]), want.cz);
                if (m_axis_tdata[49:48] !== want.st)
                    report_mismatch("status", m_axis_tdata[49:48], want.st);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extremes of every coordinate bit, zero volume, single faces and multi-face meshes.
    task automatic test_directed;
        vec_t z, mx, mn, ex, ey, ez;
        z  = '{x: 0, y: 0, z: 0};
        mx = '{x: 16'sh7FFF, y: 16'sh7FFF, z: 16'sh7FFF};
        mn = '{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000};
        ex = '{x: 16'sh1000, y: 0, z: 0};
        ey = '{x: 0, y: 16'sh1000, z: 0};
        ez = '{x: 0, y: 0, z: 16'sh1000};
        // degenerate face: zero total volume
        send_face(z, z, z, 1'b1);
        send_face(mx, mx, mx, 1'b1);
        // unit-ish tetrahedron faces, both orientations
        send_face(ex, ey, ez, 1'b1);
        send_face(ex, ez, ey, 1'b1);
        // extremes on all axes, likely clamped center
        send_face('{x: 16'sh8000, y: 0, z: 0}, '{x: 0, y: 16'sh7FFF, z: 0},
                  '{x: 0, y: 0, z: 16'sh8000}, 1'b1);
        send_face(mn, '{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh7FFF},
                  '{x: 16'sh8000, y: 16'sh7FFF, z: 16'sh7FFF}, 1'b1);
        send_face('{x: 16'sh7FFF, y: 16'sh8000, z: 0}, '{x: 0, y: 16'sh7FFF, z: 16'sh8000},
                  '{x: 16'sh8000, y: 0, z: 16'sh7FFF}, 1'b0);
        send_face(mx, mn, ex, 1'b1);
        // closed tetrahedron (four faces) offset from the origin
        begin
            vec_t p0, p1, p2, p3;
            p0 = '{x: 16'sh0800, y: 16'sh0800, z: 16'sh0800};
            p1 = '{x: 16'sh1800, y: 16'sh0800, z: 16'sh0800};
            p2 = '{x: 16'sh0800, y: 16'sh1800, z: 16'sh0800};
            p3 = '{x: 16'sh0800, y: 16'sh0800, z: 16'sh1800};
            send_face(p0, p2, p1, 1'b0);
            send_face(p0, p1, p3, 1'b0);
            send_face(p0, p3, p2, 1'b0);
            send_face(p1, p2, p3, 1'b1);
            // same tetrahedron with reversed winding
            send_face(p0, p1, p2, 1'b0);
            send_face(p0, p3, p1, 1'b0);
            send_face(p0, p2, p3, 1'b0);
            send_face(p1, p3, p2, 1'b1);
        end
        // a face and its reverse cancel: zero volume over two faces
        send_face(ex, ey, mx, 1'b0);
        send_face(ex, mx, ey, 1'b1);
        drain();
    endtask

    // Mostly small meshes with full-range and small coordinates, random gaps.
    task automatic test_random_meshes;
        int sent;
        sent = 0;
        while (sent < 600)
        begin
            int n;
            n = $urandom_range(1, 10);
            send_rand_mesh(n, ($urandom_range(0, 2) == 0) ? 32768 : 4096);
            sent += n;
            if ($urandom_range(0, 7) == 0)
            begin
                send_busy_free = ~send_busy_free;
                recv_busy_free = ~recv_busy_free;
            end
        end
        send_busy_free = 1'b0;
        recv_busy_free = 1'b0;
        drain();
    endtask

    // Receiver stops for a long stretch while short meshes keep coming.
    task automatic test_backpressure;
        send_busy_free = 1'b1;
        hold_cycles    = 3000;
        repeat (2) @(posedge clk);
        for (int i = 0; i < 12; i++)
            send_rand_mesh($urandom_range(1, 3), 4096);
        send_busy_free = 1'b0;
        drain();
    endtask

    initial
    begin
        vol_acc        = '0;
        wsum_x         = '0;
        wsum_y         = '0;
        wsum_z         = '0;
        sum_ovf        = 1'b0;
        err_count      = 0;
        send_busy_free = 1'b0;
        recv_busy_free = 1'b0;
        hold_cycles    = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_meshes();
        test_backpressure();

        // allow spare time for the divider after the last beat
        repeat (500) @(posedge clk);
        if (err_count == 0 && centroid_q.size() == 0)
            $display("[mesh_center_of_mass_core] OK");
        else
            $display("[mesh_center_of_mass_core] ERROR");
        $finish;
    end

endmodule
